/* hdl/acra_pkg.sv */
// Package for the aligned capture region allocator.
// Holds the shared constants, item and control types, and the texel size table.
// No dependencies.
`default_nettype none

package acra_pkg;

    localparam int SLOT_COUNT  = 4;
    localparam int ALIGN_BYTES = 16;
    localparam int SLOT_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam int ADDR_W  = 41;
    localparam int OFF_W   = ADDR_W + 1;
    localparam int CNT_W   = 32;
    localparam int WH_W    = 30;
    localparam int DL_W    = 24;
    localparam int PROD_W  = WH_W + DL_W;
    localparam int SIZE_W  = PROD_W + 4;
    localparam int TOTAL_W = SIZE_W + 1;
    localparam int CAP_W   = 56;

    localparam logic [ADDR_W-1:0] BUDGET_RESET = ADDR_W'(16777216);
    localparam logic [OFF_W-1:0]  ALIGN_MASK   = OFF_W'(ALIGN_BYTES - 1);

    localparam logic [7:0] FMT_D24_S8 = 8'd129;
    localparam logic [7:0] FMT_D32_S8 = 8'd130;

    localparam logic MODE_BEGIN   = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    localparam logic [2:0] RS_COMMITTED  = 3'd0;
    localparam logic [2:0] RS_FRAME      = 3'd1;
    localparam logic [2:0] RS_NO_SLOT    = 3'd2;
    localparam logic [2:0] RS_EMPTY      = 3'd3;
    localparam logic [2:0] RS_NOT_SOURCE = 3'd4;
    localparam logic [2:0] RS_BAD_FORMAT = 3'd5;
    localparam logic [2:0] RS_OVER       = 3'd6;
    localparam logic [2:0] RS_NO_IMAGE   = 3'd7;

    localparam logic [1:0] ASPECT_COLOR   = 2'd0;
    localparam logic [1:0] ASPECT_DEPTH   = 2'd1;
    localparam logic [1:0] ASPECT_STENCIL = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL1 = 4'b0010,
        S_MUL2 = 4'b0100,
        S_DONE = 4'b1000
    } acra_state_t;

    typedef struct packed {
        logic load;
        logic mul1;
        logic mul2;
        logic commit;
    } acra_cmd_t;

    typedef struct packed {
        logic out_full;
    } acra_sts_t;

    typedef struct packed {
        logic        mode;
        logic [3:0]  slot;
        logic [7:0]  format;
        logic        has_depth;
        logic        has_stencil;
        logic        copy_source_ok;
        logic [14:0] width;
        logic [14:0] height;
        logic [11:0] depth_slices;
        logic [11:0] layers;
        logic        image_present;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [1:0]        copy_aspect;
        logic [ADDR_W-1:0] region_offset;
        logic [CAP_W-1:0]  copy_bytes;
        logic [ADDR_W-1:0] cursor_after;
        logic [CNT_W-1:0]  budget_drops;
        logic [CNT_W-1:0]  format_drops;
    } out_item_t;

    typedef struct packed {
        logic       ok;
        logic [2:0] shift;
    } texel_t;

    function automatic texel_t texel_lookup(input logic [7:0] fmt);
        texel_t t;
        t = '0;
        case (fmt)
            8'd9, 8'd10, 8'd13, 8'd14, 8'd127: begin
                t.ok = 1'b1; t.shift = 3'd0;
            end
            8'd16, 8'd17, 8'd20, 8'd70, 8'd71, 8'd74, 8'd75, 8'd76, 8'd124: begin
                t.ok = 1'b1; t.shift = 3'd1;
            end
            8'd37, 8'd38, 8'd41, 8'd43, 8'd44, 8'd50, 8'd58, 8'd64, 8'd77, 8'd78,
            8'd81, 8'd83, 8'd98, 8'd99, 8'd100, 8'd122, 8'd123, 8'd125, 8'd126,
            8'd129: begin
                t.ok = 1'b1; t.shift = 3'd2;
            end
            8'd91, 8'd92, 8'd95, 8'd97, 8'd101, 8'd103: begin
                t.ok = 1'b1; t.shift = 3'd3;
            end
            8'd107, 8'd108, 8'd109: begin
                t.ok = 1'b1; t.shift = 3'd4;
            end
            default: begin
                t = '0;
            end
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

/* hdl/acra_ctrl.sv */
// Controller of the aligned capture region allocator.
// Sequences accept, two multiply steps and the commit; uses acra_pkg.
`default_nettype none

module acra_ctrl import acra_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire logic      m_tready,
    input  wire acra_sts_t sts,
    output acra_cmd_t      cmd
);

    acra_state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_MUL1;
                end
            end
            S_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!sts.out_full || m_tready) begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/acra_dp.sv */
// Datapath of the aligned capture region allocator.
// Holds the budget, slot state, size multiplies and the result register; uses acra_pkg.
`default_nettype none

module acra_dp import acra_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire acra_cmd_t         cmd,
    output acra_sts_t              sts,
    input  wire in_item_t          in_item,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [ADDR_W-1:0] cfg_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output out_item_t              out_item
);

    logic [ADDR_W-1:0] budget_reg;
    logic              active_valid_reg, active_valid_next;
    logic [SLOT_W-1:0] active_slot_reg, active_slot_next;
    logic [ADDR_W-1:0] cursor_reg [SLOT_COUNT];
    logic [CNT_W-1:0]  bdrop_reg  [SLOT_COUNT];
    logic [CNT_W-1:0]  fdrop_reg  [SLOT_COUNT];

    in_item_t          item_reg;
    logic [WH_W-1:0]   wh_reg;
    logic [DL_W-1:0]   dl_reg;
    logic [OFF_W-1:0]  off_reg;
    texel_t            tex_reg;
    logic [PROD_W-1:0] prod_reg;

    logic              out_valid_reg;
    out_item_t         out_reg, res;

    texel_t            tex;
    logic [OFF_W-1:0]  off_next;
    logic [1:0]        aspect;
    logic [SIZE_W-1:0] size_full;
    logic [TOTAL_W-1:0] total;
    logic              empty;
    logic [ADDR_W-1:0] cur_rd, cur_new;
    logic [CNT_W-1:0]  bd_rd, bd_new, fd_rd, fd_new;
    logic [SLOT_W-1:0] wr_idx;
    logic              wr_en;

    assign cfg_ready    = 1'b1;
    assign sts.out_full = out_valid_reg;
    assign out_valid    = out_valid_reg;
    assign out_item     = out_reg;

    assign cur_rd = cursor_reg[active_slot_reg];
    assign bd_rd  = bdrop_reg[active_slot_reg];
    assign fd_rd  = fdrop_reg[active_slot_reg];

    always_comb begin
        tex = texel_lookup(item_reg.format);
        if ((item_reg.format == FMT_D24_S8 || item_reg.format == FMT_D32_S8)
                && item_reg.has_depth) begin
            tex.ok    = 1'b1;
            tex.shift = 3'd2;
        end
        off_next = ({1'b0, cur_rd} + ALIGN_MASK) & ~ALIGN_MASK;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg <= in_item;
        end
        if (cmd.mul1) begin
            wh_reg  <= WH_W'(item_reg.width) * WH_W'(item_reg.height);
            dl_reg  <= DL_W'(item_reg.depth_slices) * DL_W'(item_reg.layers);
            off_reg <= off_next;
            tex_reg <= tex;
        end
        if (cmd.mul2) begin
            prod_reg <= PROD_W'(wh_reg) * PROD_W'(dl_reg);
        end
        if (cmd.commit) begin
            out_reg <= res;
        end
    end

    always_comb begin
        res               = '0;
        active_valid_next = active_valid_reg;
        active_slot_next  = active_slot_reg;
        wr_idx            = active_slot_reg;
        wr_en             = 1'b0;
        cur_new           = cur_rd;
        bd_new            = bd_rd;
        fd_new            = fd_rd;
        aspect            = item_reg.has_depth ? ASPECT_DEPTH :
                            (item_reg.has_stencil ? ASPECT_STENCIL : ASPECT_COLOR);
        empty             = (item_reg.width == '0) || (item_reg.height == '0)
                            || (item_reg.depth_slices == '0) || (item_reg.layers == '0);
        size_full         = {4'b0, prod_reg} << tex_reg.shift;
        total             = TOTAL_W'(off_reg) + TOTAL_W'(size_full);

        if (item_reg.mode == MODE_BEGIN) begin
            if ({1'b0, item_reg.slot} < 5'(SLOT_COUNT)) begin
                active_valid_next = 1'b1;
                active_slot_next  = item_reg.slot[SLOT_W-1:0];
                wr_idx            = item_reg.slot[SLOT_W-1:0];
                wr_en             = 1'b1;
                cur_new           = '0;
                bd_new            = '0;
                fd_new            = '0;
                res.status        = RS_FRAME;
            end else begin
                active_valid_next = 1'b0;
                res.status        = RS_NO_SLOT;
            end
        end else begin
            res.copy_aspect = aspect;
            if (!active_valid_reg) begin
                res.status = RS_NO_SLOT;
            end else if (empty) begin
                res.status = RS_EMPTY;
            end else if (!item_reg.copy_source_ok) begin
                fd_new     = fd_rd + CNT_W'(1);
                wr_en      = 1'b1;
                res.status = RS_NOT_SOURCE;
            end else if (!tex_reg.ok) begin
                fd_new     = fd_rd + CNT_W'(1);
                wr_en      = 1'b1;
                res.status = RS_BAD_FORMAT;
            end else if (total > TOTAL_W'(budget_reg)) begin
                bd_new     = bd_rd + CNT_W'(1);
                wr_en      = 1'b1;
                res.status = RS_OVER;
            end else begin
                res.region_offset = off_reg[ADDR_W-1:0];
                res.copy_bytes    = (size_full[SIZE_W-1:CAP_W] != '0) ? '1
                                    : size_full[CAP_W-1:0];
                if (item_reg.image_present) begin
                    cur_new    = total[ADDR_W-1:0];
                    wr_en      = 1'b1;
                    res.status = RS_COMMITTED;
                end else begin
                    res.status = RS_NO_IMAGE;
                end
            end
            if (active_valid_reg) begin
                res.cursor_after = cur_new;
                res.budget_drops = bd_new;
                res.format_drops = fd_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            budget_reg       <= BUDGET_RESET;
            active_valid_reg <= 1'b0;
            active_slot_reg  <= '0;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                cursor_reg[i] <= '0;
                bdrop_reg[i]  <= '0;
                fdrop_reg[i]  <= '0;
            end
        end else begin
            if (cfg_valid) begin
                budget_reg <= cfg_data;
            end
            if (cmd.commit) begin
                active_valid_reg <= active_valid_next;
                active_slot_reg  <= active_slot_next;
                if (wr_en) begin
                    cursor_reg[wr_idx] <= cur_new;
                    bdrop_reg[wr_idx]  <= bd_new;
                    fdrop_reg[wr_idx]  <= fd_new;
                end
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/aligned_capture_region_allocator_unit.sv */
// Top level of the aligned capture region allocator.
// Instantiates acra_ctrl and acra_dp; uses acra_pkg.
//
// Usage: a request on the s_ channel is either a begin-frame (s_tuser 0) that
// activates one of the frame slots and clears its cursor and drop counters,
// or a capture request (s_tuser 1) that is checked and, if admitted, given an
// aligned byte region of the active slot. Every request yields one result on
// the m_ channel, with the status code on m_tuser.
// The budget register is written through cfg_valid/cfg_data; cfg_ready is
// always high. Write it only while no request is in flight.
// A request moves through the accept, two multiply and commit steps; its result
// is registered at the commit. A new request is accepted only after the last one
// is committed, as the two-step size multiply lies ahead of the budget compare.
// The result sits in an output register, so the next request is accepted
// while a result waits; a stalled m_tready holds at most one further request
// in the commit step until the register frees up.
// Reset clears the budget to 16 MiB, deactivates all slots and zeroes every
// slot's cursor and counters.
`default_nettype none

module aligned_capture_region_allocator_unit import acra_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // slot, format, has_depth, has_stencil, copy_source_ok, width, height,
    // depth_slices, layers, image_present; zero padded to 72 bits
    input  wire logic [71:0]       s_tdata,
    // mode
    input  wire logic [0:0]        s_tuser,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // copy_aspect, region_offset, capture_size, bytes_used, budget_drops,
    // format_drops; zero padded to 208 bits
    output logic [207:0]           m_tdata,
    // status
    output logic [2:0]             m_tuser,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [ADDR_W-1:0] cfg_data
);

    in_item_t  in_item;
    out_item_t out_item;
    acra_cmd_t cmd;
    acra_sts_t sts;

    always_comb begin
        in_item.mode           = s_tuser[0];
        in_item.slot           = s_tdata[3:0];
        in_item.format         = s_tdata[11:4];
        in_item.has_depth      = s_tdata[12];
        in_item.has_stencil    = s_tdata[13];
        in_item.copy_source_ok = s_tdata[14];
        in_item.width          = s_tdata[29:15];
        in_item.height         = s_tdata[44:30];
        in_item.depth_slices   = s_tdata[56:45];
        in_item.layers         = s_tdata[68:57];
        in_item.image_present  = s_tdata[69];
    end

    assign m_tuser = out_item.status;
    assign m_tdata = {4'b0, out_item.format_drops, out_item.budget_drops,
                      out_item.cursor_after, out_item.copy_bytes,
                      out_item.region_offset, out_item.copy_aspect};

    acra_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    acra_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sts       (sts),
        .in_item   (in_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

/* tb/aligned_capture_region_allocator_unit_tb.sv */
// Testbench for aligned_capture_region_allocator_unit: directed and random capture requests
// checked against an in-bench model of slot cursors, budget and drop counters.
// Depends on acra_pkg and the aligned_capture_region_allocator_unit RTL.
module aligned_capture_region_allocator_unit_tb;
    import acra_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam logic [63:0] CAP_MAX = (64'd1 << CAP_W) - 64'd1;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [71:0]       s_tdata = '0;
    logic [0:0]        s_tuser = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [207:0]      m_tdata;
    logic [2:0]        m_tuser;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [ADDR_W-1:0] cfg_data = '0;

    // Model state of the allocator.
    logic [ADDR_W-1:0] budget_bytes = BUDGET_RESET;
    bit                frame_live = 1'b0;
    int                frame_slot = 0;
    logic [ADDR_W-1:0] used_bytes [SLOT_COUNT] = '{default: '0};
    logic [CNT_W-1:0]  over_count [SLOT_COUNT] = '{default: '0};
    logic [CNT_W-1:0]  fmt_count  [SLOT_COUNT] = '{default: '0};

    out_item_t pending_results [$];
    int        mismatches = 0;
    int        idle_cycles = 0;
    bit        quiet = 1'b0;

    aligned_capture_region_allocator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic int draw_gap();
        return quiet ? 0 : int'($urandom_range(0, 3));
    endfunction

    function automatic logic [63:0] texel_bytes(input logic [7:0] f);
        case (f)
            8'd9, 8'd10, 8'd13, 8'd14, 8'd127:
                return 64'd1;
            8'd16, 8'd17, 8'd20, 8'd70, 8'd71, 8'd74, 8'd75, 8'd76, 8'd124:
                return 64'd2;
            8'd37, 8'd38, 8'd41, 8'd43, 8'd44, 8'd50, 8'd58, 8'd64, 8'd77, 8'd78,
            8'd81, 8'd83, 8'd98, 8'd99, 8'd100, 8'd122, 8'd123, 8'd125, 8'd126,
            8'd129:
                return 64'd4;
            8'd91, 8'd92, 8'd95, 8'd97, 8'd101, 8'd103:
                return 64'd8;
            8'd107, 8'd108, 8'd109:
                return 64'd16;
            default:
                return 64'd0;
        endcase
    endfunction

    // Applies one request to the model and returns the result the block must give.
    function automatic out_item_t admit_capture(input in_item_t it);
        out_item_t   r;
        logic [63:0] stride;
        logic [63:0] sz;
        logic [63:0] off;
        r = '0;
        if (it.mode == MODE_BEGIN) begin
            if (int'(it.slot) < SLOT_COUNT) begin
                frame_live = 1'b1;
                frame_slot = int'(it.slot);
                used_bytes[frame_slot] = '0;
                over_count[frame_slot] = '0;
                fmt_count[frame_slot] = '0;
                r.status = RS_FRAME;
            end else begin
                frame_live = 1'b0;
                r.status = RS_NO_SLOT;
            end
        end else begin
            if (it.has_depth)
                r.copy_aspect = ASPECT_DEPTH;
            else if (it.has_stencil)
                r.copy_aspect = ASPECT_STENCIL;
            if (!frame_live) begin
                r.status = RS_NO_SLOT;
            end else if (it.width == 0 || it.height == 0 || it.depth_slices == 0 ||
                         it.layers == 0) begin
                r.status = RS_EMPTY;
            end else if (!it.copy_source_ok) begin
                fmt_count[frame_slot] += 1;
                r.status = RS_NOT_SOURCE;
            end else begin
                if ((it.format == FMT_D24_S8 || it.format == FMT_D32_S8) &&
                    r.copy_aspect == ASPECT_DEPTH)
                    stride = 64'd4;
                else
                    stride = texel_bytes(it.format);
                if (stride == 0) begin
                    fmt_count[frame_slot] += 1;
                    r.status = RS_BAD_FORMAT;
                end else begin
                    sz = stride * 64'(it.width) * 64'(it.height) *
                         64'(it.depth_slices) * 64'(it.layers);
                    off = (64'(used_bytes[frame_slot]) + 64'(ALIGN_BYTES - 1)) /
                          64'(ALIGN_BYTES) * 64'(ALIGN_BYTES);
                    if (off + sz > 64'(budget_bytes)) begin
                        over_count[frame_slot] += 1;
                        r.status = RS_OVER;
                    end else begin
                        r.region_offset = off[ADDR_W-1:0];
                        r.copy_bytes = (sz > CAP_MAX) ? CAP_MAX[CAP_W-1:0] : sz[CAP_W-1:0];
                        if (it.image_present) begin
                            used_bytes[frame_slot] = ADDR_W'(off + sz);
                            r.status = RS_COMMITTED;
                        end else begin
                            r.status = RS_NO_IMAGE;
                        end
                    end
                end
            end
        end
        if (frame_live) begin
            r.cursor_after = used_bytes[frame_slot];
            r.budget_drops = over_count[frame_slot];
            r.format_drops = fmt_count[frame_slot];
        end
        return r;
    endfunction

    function automatic in_item_t frame_item(input int slot);
        in_item_t it;
        it = '0;
        it.mode = MODE_BEGIN;
        it.slot = 4'(slot);
        return it;
    endfunction

    function automatic in_item_t capture_item(input logic [7:0] f, input bit dep, sten, src,
                                              input int w, h, d, l, input bit img);
        in_item_t it;
        it = '0;
        it.mode = MODE_REQUEST;
        it.format = f;
        it.has_depth = dep;
        it.has_stencil = sten;
        it.copy_source_ok = src;
        it.width = 15'(w);
        it.height = 15'(h);
        it.depth_slices = 12'(d);
        it.layers = 12'(l);
        it.image_present = img;
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.mode;
        s_tdata <= {2'b00, it.image_present, it.layers, it.depth_slices, it.height,
                    it.width, it.copy_source_ok, it.has_stencil, it.has_depth,
                    it.format, it.slot};
        do @(posedge aclk); while (!s_tready);
        pending_results.insert(pending_results.size(), admit_capture(it));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_budget(input logic [ADDR_W-1:0] value);
        wait_idle();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        budget_bytes = value;
        cfg_valid <= 1'b0;
    endtask

    // Receiver: stalls a random number of cycles before taking each result.
    initial begin : result_sink
        int stall;
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic cmp_field(input string name, input logic [63:0] want, got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : check_results
        out_item_t  got;
        out_item_t  want;
        logic [3:0] pad;
        if (aresetn && m_tvalid && m_tready) begin
            {pad, got.format_drops, got.budget_drops, got.cursor_after, got.copy_bytes,
             got.region_offset, got.copy_aspect} = m_tdata;
            got.status = m_tuser;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual status %0d",
                         $time, got.status);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                cmp_field("status", 64'(want.status), 64'(got.status));
                cmp_field("copy_aspect", 64'(want.copy_aspect), 64'(got.copy_aspect));
                cmp_field("region_offset", 64'(want.region_offset), 64'(got.region_offset));
                cmp_field("capture_size", 64'(want.copy_bytes), 64'(got.copy_bytes));
                cmp_field("bytes_used", 64'(want.cursor_after), 64'(got.cursor_after));
                cmp_field("budget_drops", 64'(want.budget_drops), 64'(got.budget_drops));
                cmp_field("format_drops", 64'(want.format_drops), 64'(got.format_drops));
                cmp_field("padding", 64'd0, 64'(pad));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("aligned_capture_region_allocator_unit_tb failed");
            $finish;
        end
    end

    task automatic test_no_active_slot();
        send_item(capture_item(8'd37, 1'b0, 1'b0, 1'b1, 4, 4, 1, 1, 1'b1));
        send_item(frame_item(2));
        send_item(frame_item(15));
        send_item(capture_item(8'd37, 1'b0, 1'b0, 1'b1, 4, 4, 1, 1, 1'b1));
    endtask

    task automatic test_request_checks();
        send_item(frame_item(0));
        send_item(capture_item(8'd37, 1'b0, 1'b0, 1'b1, 0, 4, 1, 1, 1'b1));
        send_item(capture_item(8'd37, 1'b0, 1'b0, 1'b1, 4, 0, 1, 1, 1'b1));
        send_item(capture_item(8'd37, 1'b0, 1'b0, 1'b1, 4, 4, 0, 1, 1'b1));
        send_item(capture_item(8'd37, 1'b0, 1'b0, 1'b1, 4, 4, 1, 0, 1'b1));
        send_item(capture_item(8'd37, 1'b0, 1'b0, 1'b0, 4, 4, 1, 1, 1'b1));
        send_item(capture_item(8'd0, 1'b0, 1'b0, 1'b1, 4, 4, 1, 1, 1'b1));
        send_item(capture_item(8'd13, 1'b0, 1'b0, 1'b1, 3, 3, 1, 1, 1'b1));
        send_item(capture_item(FMT_D24_S8, 1'b1, 1'b1, 1'b1, 5, 1, 1, 1, 1'b1));
        send_item(capture_item(FMT_D32_S8, 1'b1, 1'b0, 1'b1, 2, 3, 1, 1, 1'b1));
        send_item(capture_item(FMT_D32_S8, 1'b0, 1'b1, 1'b1, 2, 3, 1, 1, 1'b1));
        send_item(capture_item(FMT_D24_S8, 1'b0, 1'b1, 1'b1, 7, 1, 1, 1, 1'b1));
        send_item(capture_item(8'd107, 1'b0, 1'b0, 1'b1, 8, 8, 2, 2, 1'b0));
        send_item(capture_item(8'd255, 1'b1, 1'b1, 1'b1, 32767, 32767, 4095, 4095, 1'b1));
        send_item(frame_item(3));
        send_item(capture_item(8'd91, 1'b0, 1'b0, 1'b1, 16384, 16384, 2048, 2048, 1'b1));
    endtask

    task automatic test_budget_extremes();
        write_budget('0);
        send_item(frame_item(1));
        send_item(capture_item(8'd9, 1'b0, 1'b0, 1'b1, 1, 1, 1, 1, 1'b1));
        write_budget('1);
        send_item(capture_item(8'd109, 1'b0, 1'b0, 1'b1, 16384, 16384, 1, 511, 1'b1));
        send_item(capture_item(8'd13, 1'b0, 1'b0, 1'b1, 3, 1, 1, 1, 1'b1));
        send_item(capture_item(8'd13, 1'b0, 1'b0, 1'b1, 16, 16, 1, 1, 1'b1));
    endtask

    function automatic in_item_t random_item();
        in_item_t    it;
        logic [95:0] noise;
        logic [7:0]  f;
        int          roll;
        roll = $urandom_range(0, 99);
        if (roll < 8) begin
            it = frame_item($urandom_range(0, SLOT_COUNT - 1));
        end else if (roll < 10) begin
            it = frame_item($urandom_range(0, 15));
        end else if (roll < 85) begin
            do f = 8'($urandom_range(0, 255));
            while (texel_bytes(f) == 0 && f != FMT_D32_S8);
            it = capture_item(f, 1'($urandom), 1'($urandom), 1'b1,
                              $urandom_range(1, 64), $urandom_range(1, 64),
                              $urandom_range(1, 2), $urandom_range(1, 4),
                              $urandom_range(0, 7) != 0);
        end else begin
            noise = {$urandom, $urandom, $urandom};
            it = noise[$bits(in_item_t)-1:0];
            if ($urandom_range(0, 3) == 0)
                it.layers = '0;
        end
        return it;
    endfunction

    task automatic test_random_traffic();
        logic [ADDR_W-1:0] setting;
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: setting = BUDGET_RESET;
                1: setting = ADDR_W'(4096);
                2: setting = ADDR_W'({$urandom, $urandom});
                3: setting = '1;
                default: setting = ADDR_W'(1);
            endcase
            write_budget(setting);
            for (int n = 0; n < 260; n++) begin
                if (n % 64 == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                send_item(random_item());
            end
            quiet = 1'b0;
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_no_active_slot();
        test_request_checks();
        test_budget_extremes();
        test_random_traffic();
        wait_idle();
        if (mismatches == 0)
            $display("aligned_capture_region_allocator_unit_tb passed");
        else
            $display("aligned_capture_region_allocator_unit_tb failed");
        $finish;
    end

endmodule
